### sv/twcm_pkg.sv
package twcm_pkg;

  localparam int unsigned NumTextures     = 4;
  localparam int unsigned TexSelW         = $clog2(NumTextures);
  localparam int unsigned StoreAw         = 14;
  localparam logic [10:0] ScreenHeightRst = 11'd480;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_START = 2'd1,
    KIND_ROW   = 2'd2
  } twcm_kind_e;

  typedef enum logic [1:0] {
    RES_ACK   = 2'd0,
    RES_DEPTH = 2'd1,
    RES_PIXEL = 2'd2
  } twcm_res_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIV  = 2'd1,
    ST_MUL  = 2'd2
  } twcm_state_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [13:0] texel_addr;
    logic [31:0] texel_color;
    logic [10:0] column;
    logic        side;
    logic        dir_x_neg;
    logic        dir_y_neg;
    logic [15:0] wall_frac;
    logic [15:0] line_height;
    logic [10:0] draw_start;
    logic [10:0] draw_end;
    logic [31:0] perp_dist;
  } twcm_in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [10:0] out_row;
    logic [10:0] out_column;
    logic [31:0] color;
    logic [31:0] depth;
    logic        last;
  } twcm_out_t;

endpackage

### sv/textured_wall_column_mapper_top.sv
// Textured wall column mapper.
// Input channel (in_valid_i / in_stall_o / in_i) carries one item per accept:
// texel loads, column starts and row requests. Output channel (out_valid_o /
// out_stall_i / out_o) returns exactly one result item per input item, in order.
// Configuration channel (cfg_valid_i / cfg_ready_o / cfg_data_i) writes the
// screen height; write it only while the block is idle.
// A result is registered first in s1_q and then in out_q, which drives out_o; an
// output stall can hold it in s1_q between the two.
// Throughput: texel loads and row requests are accepted one per cycle while the
// output does not stall. A column start runs a radix-2 restoring divider for the
// texture step, one quotient bit a cycle, then a multiply step for the start
// position; no further item is accepted until the divide and multiply are done.
// Texels live in a 16384 x 32 synchronous memory; a row request reads it in its
// accept cycle into rdata_q, and the data joins the result as it moves to out_q.
// Reset clears all control state and sets the screen height to 480; the texture
// memory is undefined until loaded.
// While out_stall_i holds, the output item is kept and at most one further item
// is taken in before in_stall_o rises.
module textured_wall_column_mapper_top
  import twcm_pkg::*;
#(
  parameter int unsigned TEX_HEIGHT = 64,
  parameter int unsigned TEX_WIDTH  = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  twcm_in_t    in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output twcm_out_t   out_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [10:0] cfg_data_i
);

  localparam int unsigned HB         = $clog2(TEX_HEIGHT);
  localparam int unsigned WB         = $clog2(TEX_WIDTH);
  localparam int unsigned QW         = HB + 17;
  localparam int unsigned CntW       = $clog2(QW + 1);
  localparam int unsigned IdxW       = TexSelW + HB + WB;
  localparam int unsigned StoreWords = 2 ** StoreAw;

  twcm_state_e state_q, state_d;
  logic busy, div_run, div_done, mul_run;

  logic [10:0]        screen_height_q;
  logic [TexSelW-1:0] cur_texture_q;
  logic [WB-1:0]      cur_tex_col_q;
  logic [31:0]        step_fixed_q;
  logic [31:0]        tex_position_q;
  logic [10:0]        cur_row_q;
  logic [10:0]        end_row_q;
  logic [10:0]        cur_column_q;

  logic [15:0]   div_q;
  logic [15:0]   rem_q;
  logic [QW-1:0] dvd_q;
  logic [CntW-1:0] cnt_q;
  logic [16:0]   term_q;

  logic          in_acc, load_acc, start_acc, row_acc, rows_left;
  logic          out_free, s1_adv;
  logic          s1_valid_q, s1_pix_q, out_valid_q;
  twcm_out_t     s1_q, s1_d, out_q, out_d;

  logic [16:0]   trial;
  logic [16:0]   diff;
  logic          ge;
  logic [QW-1:0] quot_next;
  logic [31:0]   term_ext;
  logic [31:0]   pos_mul;
  logic [16:0]   term_d;
  logic [TexSelW-1:0] tex_sel_d;
  logic [WB-1:0] tex_col_raw, tex_col_d;

  logic [IdxW-1:0]         idx_full;
  logic [IdxW+StoreAw-1:0] addr_wide;
  logic [StoreAw-1:0]      rd_addr;

  logic [31:0] mem_q [StoreWords];
  logic [31:0] rdata_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (start_acc) state_d = ST_DIV;
      ST_DIV:  if (div_done) state_d = ST_MUL;
      ST_MUL:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    busy     = (state_q != ST_IDLE);
    div_run  = (state_q == ST_DIV);
    div_done = div_run && (cnt_q == CntW'(QW - 1));
    mul_run  = (state_q == ST_MUL);
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = busy || (s1_valid_q && !out_free);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign rows_left  = (cur_row_q < end_row_q);
  assign load_acc   = in_acc && (in_i.kind == KIND_LOAD);
  assign start_acc  = in_acc && (in_i.kind == KIND_START);
  assign row_acc    = in_acc && (in_i.kind == KIND_ROW) && rows_left;

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assign trial     = {rem_q, dvd_q[QW-1]};
  assign ge        = (trial >= {1'b0, div_q});
  assign diff      = trial - {1'b0, div_q};
  assign quot_next = {dvd_q[QW-2:0], ge};
  assign term_ext  = {{15{term_q[16]}}, term_q};
  assign pos_mul   = term_ext * step_fixed_q;

  assign term_d = {6'b0, in_i.draw_start} + {2'b0, in_i.line_height[15:1]}
                - {7'b0, screen_height_q[10:1]};

  always_comb begin
    if (in_i.side) begin
      tex_sel_d = in_i.dir_y_neg ? TexSelW'(1) : TexSelW'(0);
    end else begin
      tex_sel_d = in_i.dir_x_neg ? TexSelW'(2) : TexSelW'(3);
    end
    tex_col_raw = in_i.wall_frac[15 -: WB];
    if ((!in_i.side && !in_i.dir_x_neg) || (in_i.side && in_i.dir_y_neg)) begin
      tex_col_d = ~tex_col_raw;
    end else begin
      tex_col_d = tex_col_raw;
    end
  end

  assign idx_full  = {cur_texture_q, tex_position_q[16 +: HB], cur_tex_col_q};
  assign addr_wide = {{StoreAw{1'b0}}, idx_full};
  assign rd_addr   = addr_wide[StoreAw-1:0];

  always_comb begin
    s1_d             = '0;
    s1_d.result_kind = RES_ACK;
    if (start_acc) begin
      s1_d.result_kind = RES_DEPTH;
      s1_d.out_column  = in_i.column;
      s1_d.depth       = in_i.perp_dist;
    end else if (row_acc) begin
      s1_d.result_kind = RES_PIXEL;
      s1_d.out_row     = cur_row_q;
      s1_d.out_column  = cur_column_q;
      s1_d.last        = (({1'b0, cur_row_q} + 12'd1) == {1'b0, end_row_q});
    end
  end

  always_comb begin
    out_d = s1_q;
    if (s1_pix_q) begin
      out_d.color = rdata_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      screen_height_q <= ScreenHeightRst;
      cur_texture_q   <= '0;
      cur_tex_col_q   <= '0;
      step_fixed_q    <= '0;
      tex_position_q  <= '0;
      cur_row_q       <= '0;
      end_row_q       <= '0;
      cur_column_q    <= '0;
      cnt_q           <= '0;
      s1_valid_q      <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        screen_height_q <= cfg_data_i;
      end
      if (start_acc) begin
        cur_texture_q <= tex_sel_d;
        cur_tex_col_q <= tex_col_d;
        cur_row_q     <= in_i.draw_start;
        end_row_q     <= in_i.draw_end;
        cur_column_q  <= in_i.column;
        cnt_q         <= '0;
      end else if (row_acc) begin
        tex_position_q <= tex_position_q + step_fixed_q;
        cur_row_q      <= cur_row_q + 11'd1;
      end
      if (div_run) begin
        cnt_q <= cnt_q + CntW'(1);
      end
      if (div_done) begin
        step_fixed_q <= 32'(quot_next);
      end
      if (mul_run) begin
        tex_position_q <= pos_mul;
      end
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_free) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_acc) begin
      div_q  <= (in_i.line_height == 16'd0) ? 16'd1 : in_i.line_height;
      rem_q  <= '0;
      dvd_q  <= QW'(TEX_HEIGHT) << 16;
      term_q <= term_d;
    end else if (div_run) begin
      rem_q <= ge ? diff[15:0] : trial[15:0];
      dvd_q <= quot_next;
    end
    if (in_acc) begin
      s1_q     <= s1_d;
      s1_pix_q <= row_acc;
    end
    if (s1_adv) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_acc) begin
      mem_q[in_i.texel_addr] <= in_i.texel_color;
    end
    if (row_acc) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

endmodule

### sv/twcm_checker.sv
module twcm_checker
  import twcm_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input twcm_in_t  in_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input twcm_out_t out_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_o))
    else $error("output item changed while stalled");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.result_kind == RES_ACK || out_o.result_kind == RES_DEPTH
                     || out_o.result_kind == RES_PIXEL))
    else $error("illegal result kind");

  a_last_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.last |-> out_o.result_kind == RES_PIXEL)
    else $error("last flag on a non-pixel item");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_i.kind == KIND_START |=> in_stall_o)
    else $error("item taken during column set-up");

endmodule

bind textured_wall_column_mapper_top twcm_checker u_twcm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_i        (in_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_o       (out_o)
);
